// ----- src/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Sizes, function and status codes, cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 7;
  localparam int FOUND_W  = 8;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W + 1 : POS_W + 1;

  localparam logic [FOUND_W-1:0] FOUND_NONE = {FOUND_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_END   = 3'd1,
    FN_INS_POS   = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_END   = 3'd4,
    FN_DEL_POS   = 3'd5,
    FN_SEARCH    = 3'd6,
    FN_NOP       = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         idx;
    logic [LEN_W-1:0]         len;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- src/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values
// Timing: inserts, deletes and no-ops answer in the cycle after the request is
//   taken; a search on a non-empty list registers the match row, then the result.
// Throughput: one request per cycle while the result side keeps up; a search
//   holds the input in S_SEARCH while the registered match row is encoded.
// Reset: rst clears the length, the sequencer and the result valid flag; the
//   result payload and list cells are not cleared (slots at or past the length
//   are never read).
// ----------------------------------------------------------------------------
`default_nettype none
module positional_list_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // func[2:0], value[34:3], position[41:35]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // status[1:0], found_position[9:2], count[16:10]
);

  // Request fields
  logic [ple_pkg::FUNC_W-1:0]   req_func;
  logic signed [ple_pkg::DATA_W-1:0] req_value;
  logic [ple_pkg::POS_W-1:0]    req_pos;

  assign req_func  = s_tdata[2:0];
  assign req_value = $signed(s_tdata[34:3]);
  assign req_pos   = s_tdata[41:35];

  // Control state
  ple_pkg::state_t              state, state_next;
  logic [ple_pkg::LEN_W-1:0]    len, len_next;

  // Result register
  ple_pkg::status_t             res_status;
  logic [ple_pkg::FOUND_W-1:0]  res_found;
  logic [ple_pkg::COUNT_W-1:0]  res_count;

  logic                         s_accept;
  logic                         res_load;

  // Decode outputs
  ple_pkg::status_t             dec_status;
  ple_pkg::cell_op_t            dec_op;
  logic [ple_pkg::IDX_W-1:0]    dec_idx;
  logic                         dec_search;
  logic [ple_pkg::FOUND_W-1:0]  dec_found;

  ple_pkg::cell_ctl_t           ctl;
  logic                         found_any;
  logic [ple_pkg::IDX_W-1:0]    found_idx;

  logic                         list_empty;
  logic                         list_full;
  logic [ple_pkg::CMP_W-1:0]    pos_ext;
  logic [ple_pkg::CMP_W-1:0]    len_ext;
  logic [ple_pkg::CMP_W-1:0]    pos_m1;
  logic [ple_pkg::IDX_W-1:0]    last_idx;

  assign list_empty = (len == '0);
  assign list_full  = (len >= ple_pkg::LEN_W'(ple_pkg::CAPACITY));
  assign pos_ext    = ple_pkg::CMP_W'(req_pos);
  assign len_ext    = ple_pkg::CMP_W'(len);
  assign pos_m1     = pos_ext - ple_pkg::CMP_W'(1);
  assign last_idx   = ple_pkg::IDX_W'(len - ple_pkg::LEN_W'(1));

  // Take a request only when idle and the result slot is free or draining
  assign s_tready = (state == ple_pkg::S_IDLE) && (!m_tvalid || m_tready);
  assign s_accept = s_tvalid && s_tready;

  // Work out status, cell operation and slot index for the request
  always_comb begin
    dec_status = ple_pkg::ST_OK;
    dec_op     = ple_pkg::CELL_HOLD;
    dec_idx    = '0;
    dec_search = 1'b0;
    dec_found  = '0;
    case (ple_pkg::func_t'(req_func))
      ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_END: begin
        if (list_full) begin
          dec_status = ple_pkg::ST_FULL;
        end else begin
          dec_op  = ple_pkg::CELL_INS;
          dec_idx = (req_func == ple_pkg::FN_INS_FRONT) ? '0 : ple_pkg::IDX_W'(len);
        end
      end
      ple_pkg::FN_INS_POS: begin
        if (list_empty) begin
          dec_status = ple_pkg::ST_EMPTY;
        end else if (list_full) begin
          dec_status = ple_pkg::ST_FULL;
        end else begin
          dec_op = ple_pkg::CELL_INS;
          if (pos_ext <= ple_pkg::CMP_W'(1)) begin
            dec_idx = '0;
          end else if (pos_m1 > len_ext) begin
            dec_idx = ple_pkg::IDX_W'(len);
          end else begin
            dec_idx = ple_pkg::IDX_W'(pos_m1);
          end
        end
      end
      ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_END: begin
        if (list_empty) begin
          dec_status = ple_pkg::ST_EMPTY;
        end else begin
          dec_op  = ple_pkg::CELL_DEL;
          dec_idx = (req_func == ple_pkg::FN_DEL_FRONT) ? '0 : last_idx;
        end
      end
      ple_pkg::FN_DEL_POS: begin
        if (list_empty) begin
          dec_status = ple_pkg::ST_EMPTY;
        end else if (req_pos == '0) begin
          dec_status = ple_pkg::ST_BADPOS;
        end else begin
          dec_op  = ple_pkg::CELL_DEL;
          dec_idx = (pos_ext >= len_ext) ? last_idx : ple_pkg::IDX_W'(pos_m1);
        end
      end
      ple_pkg::FN_SEARCH: begin
        dec_found = ple_pkg::FOUND_NONE;
        if (list_empty) begin
          dec_status = ple_pkg::ST_EMPTY;
        end else begin
          dec_search = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Broadcast to the cells; the key rides in value for search too
  always_comb begin
    ctl.op    = s_accept ? dec_op : ple_pkg::CELL_HOLD;
    ctl.idx   = dec_idx;
    ctl.len   = len;
    ctl.value = req_value;
  end

  ple_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .found_any (found_any),
    .found_idx (found_idx)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ple_pkg::S_IDLE: begin
        if (s_accept && dec_search) begin
          state_next = ple_pkg::S_SEARCH;
        end
      end
      ple_pkg::S_SEARCH: begin
        state_next = ple_pkg::S_IDLE;
      end
      default: begin
        state_next = ple_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: when to load the result register
  always_comb begin
    res_load = 1'b0;
    case (state)
      ple_pkg::S_IDLE:   res_load = s_accept && !dec_search;
      ple_pkg::S_SEARCH: res_load = 1'b1;
      default:           res_load = 1'b0;
    endcase
  end

  // Length follows the cell operation
  always_comb begin
    len_next = len;
    if (s_accept) begin
      case (dec_op)
        ple_pkg::CELL_INS: len_next = len + ple_pkg::LEN_W'(1);
        ple_pkg::CELL_DEL: len_next = len - ple_pkg::LEN_W'(1);
        default:           len_next = len;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ple_pkg::S_IDLE;
      len      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload: search answers from the registered match row
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_count <= ple_pkg::COUNT_W'(len_next);
      if (state == ple_pkg::S_SEARCH) begin
        res_status <= ple_pkg::ST_OK;
        res_found  <= found_any ?
                      ple_pkg::FOUND_W'(found_idx) + ple_pkg::FOUND_W'(1) :
                      ple_pkg::FOUND_NONE;
      end else begin
        res_status <= dec_status;
        res_found  <= dec_found;
      end
    end
  end

  assign m_tdata = {7'd0, res_count, res_found, res_status};

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= ple_pkg::LEN_W'(ple_pkg::CAPACITY))
    else $error("list length above capacity");

  a_search_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ple_pkg::S_SEARCH |-> !s_tready)
    else $error("request taken during search encode");

  a_update_answers: assert property (@(posedge clk) disable iff (rst)
    s_accept && !dec_search |=> m_tvalid)
    else $error("no result after update request");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_status == ple_pkg::ST_FULL |->
      res_count == ple_pkg::COUNT_W'(ple_pkg::CAPACITY))
    else $error("full status with short list");

  a_len_stable_search: assert property (@(posedge clk) disable iff (rst)
    state == ple_pkg::S_SEARCH |-> $stable(len))
    else $error("length moved during search");

endmodule
`default_nettype wire

// ----- src/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell: one list slot
// Holds one entry, shifts from a neighbor on insert or delete, flags a match.
// ----------------------------------------------------------------------------
`default_nettype none
module ple_cell (
  input  wire logic                         clk,
  input  wire ple_pkg::cell_ctl_t           ctl,
  input  wire logic [ple_pkg::IDX_W-1:0]    cell_idx,
  input  wire logic [ple_pkg::DATA_W-1:0]   left_data,
  input  wire logic [ple_pkg::DATA_W-1:0]   right_data,
  output logic      [ple_pkg::DATA_W-1:0]   data,
  output logic                              match
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      ple_pkg::CELL_INS: begin
        if (cell_idx > ctl.idx) begin
          data <= left_data;
        end else if (cell_idx == ctl.idx) begin
          data <= $unsigned(ctl.value);
        end
      end
      ple_pkg::CELL_DEL: begin
        if (cell_idx >= ctl.idx) begin
          data <= right_data;
        end
      end
      default: begin
      end
    endcase
  end

  // Only slots below the current length take part in a search
  always_ff @(posedge clk) begin
    match <= ({1'b0, cell_idx} < ctl.len) && (data == $unsigned(ctl.value));
  end

endmodule
`default_nettype wire

// ----- src/ple_chain.sv -----
// ----------------------------------------------------------------------------
// ple_chain: row of list cells with first-match encoder
// Cell i holds list position i+1; neighbors feed shifts both ways.
// ----------------------------------------------------------------------------
`default_nettype none
module ple_chain (
  input  wire logic                       clk,
  input  wire ple_pkg::cell_ctl_t         ctl,
  output logic                            found_any,
  output logic [ple_pkg::IDX_W-1:0]       found_idx
);

  logic [ple_pkg::DATA_W-1:0]   cell_data [ple_pkg::CAPACITY];
  logic [ple_pkg::CAPACITY-1:0] match;

  for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
    logic [ple_pkg::DATA_W-1:0] left_data;
    logic [ple_pkg::DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = $unsigned(ctl.value);
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == ple_pkg::CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_idx   (ple_pkg::IDX_W'(i)),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .match      (match[i])
    );
  end

  // Lowest matching slot wins
  always_comb begin
    found_any = 1'b0;
    found_idx = '0;
    for (int i = ple_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_any = 1'b1;
        found_idx = ple_pkg::IDX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire
